### hw/rtl/sc1a_pkg.sv
package sc1a_pkg;

  localparam int MaxRes = 4;
  localparam int MapSize = 58;

  localparam logic [7:0] SC_PREFIX  = 8'hE0;
  localparam logic [6:0] SC_LSHIFT  = 7'h2A;
  localparam logic [6:0] SC_RSHIFT  = 7'h36;
  localparam logic [6:0] SC_ALT     = 7'h38;
  localparam logic [6:0] SC_CTRL    = 7'h1D;
  localparam logic [7:0] SC_F1      = 8'h3B;
  localparam logic [7:0] SC_F10     = 8'h44;
  localparam logic [7:0] SC_F11     = 8'h57;
  localparam logic [7:0] SC_F12     = 8'h58;
  localparam logic [7:0] SC_UP      = 8'h48;
  localparam logic [7:0] SC_DOWN    = 8'h50;
  localparam logic [7:0] SC_LEFT    = 8'h4B;
  localparam logic [7:0] SC_RIGHT   = 8'h4D;
  localparam logic [7:0] SC_HOME    = 8'h47;
  localparam logic [7:0] SC_END     = 8'h4F;
  localparam logic [7:0] SC_INS     = 8'h52;
  localparam logic [7:0] SC_DEL     = 8'h53;

  localparam logic [6:0] CH_ESC     = 7'h1B;
  localparam logic [6:0] CH_BRACKET = 7'h5B;
  localparam logic [6:0] CH_TILDE   = 7'h7E;
  localparam logic [6:0] CTRL_MASK  = 7'h1F;

  localparam logic KIND_CHAR = 1'b0;
  localparam logic KIND_VT   = 1'b1;

  localparam logic [6:0] PLAIN_MAP [0:MapSize-1] = '{
    7'h00, 7'h1B, 7'h31, 7'h32, 7'h33, 7'h34, 7'h35, 7'h36,
    7'h37, 7'h38, 7'h39, 7'h30, 7'h2D, 7'h3D, 7'h08, 7'h09,
    7'h71, 7'h77, 7'h65, 7'h72, 7'h74, 7'h79, 7'h75, 7'h69,
    7'h6F, 7'h70, 7'h5B, 7'h5D, 7'h0A, 7'h00, 7'h61, 7'h73,
    7'h64, 7'h66, 7'h67, 7'h68, 7'h6A, 7'h6B, 7'h6C, 7'h3B,
    7'h27, 7'h60, 7'h00, 7'h5C, 7'h7A, 7'h78, 7'h63, 7'h76,
    7'h62, 7'h6E, 7'h6D, 7'h2C, 7'h2E, 7'h2F, 7'h00, 7'h2A,
    7'h00, 7'h20
  };

  localparam logic [6:0] SHIFT_MAP [0:MapSize-1] = '{
    7'h00, 7'h1B, 7'h21, 7'h40, 7'h23, 7'h24, 7'h25, 7'h5E,
    7'h26, 7'h2A, 7'h28, 7'h29, 7'h5F, 7'h2B, 7'h08, 7'h09,
    7'h51, 7'h57, 7'h45, 7'h52, 7'h54, 7'h59, 7'h55, 7'h49,
    7'h4F, 7'h50, 7'h7B, 7'h7D, 7'h0A, 7'h00, 7'h41, 7'h53,
    7'h44, 7'h46, 7'h47, 7'h48, 7'h4A, 7'h4B, 7'h4C, 7'h3A,
    7'h22, 7'h7E, 7'h00, 7'h7C, 7'h5A, 7'h58, 7'h43, 7'h56,
    7'h42, 7'h4E, 7'h4D, 7'h3C, 7'h3E, 7'h3F, 7'h00, 7'h2A,
    7'h00, 7'h20
  };

  typedef struct packed {
    logic                  kind;
    logic [3:0]            vt;
    logic [2:0]            cnt;
    logic [MaxRes-1:0][6:0] chars;
  } burst_t;

  typedef struct packed {
    logic free;
  } emit_stat_t;

endpackage

### hw/rtl/sc1a_decode.sv
module sc1a_decode (
  input  logic              clk,
  input  logic              rst_n,
  input  logic [7:0]        scancode,
  input  logic              advance,
  output sc1a_pkg::burst_t  burst
);
  import sc1a_pkg::*;

  logic shift_r, alt_r, ctrl_r, pend_r;
  logic shift_nxt, alt_nxt, ctrl_nxt, pend_nxt;
  logic       nav_hit;
  logic [6:0] nav_ch;
  logic       nav_long;
  logic [3:0] vt_num;
  logic [6:0] map_ch;
  logic [6:0] key_ch;
  logic       is_letter;

  always_comb begin
    nav_hit  = 1'b1;
    nav_long = 1'b0;
    nav_ch   = 7'h00;
    unique case (scancode)
      SC_UP:    nav_ch = 7'h41;
      SC_DOWN:  nav_ch = 7'h42;
      SC_LEFT:  nav_ch = 7'h44;
      SC_RIGHT: nav_ch = 7'h43;
      SC_HOME:  nav_ch = 7'h48;
      SC_END:   nav_ch = 7'h46;
      SC_INS: begin
        nav_ch   = 7'h32;
        nav_long = 1'b1;
      end
      SC_DEL: begin
        nav_ch   = 7'h33;
        nav_long = 1'b1;
      end
      default:  nav_hit = 1'b0;
    endcase
  end

  always_comb begin
    vt_num = 4'd0;
    if (scancode >= SC_F1 && scancode <= SC_F10) begin
      vt_num = 4'(scancode - (SC_F1 - 8'd1));
    end else if (scancode == SC_F11) begin
      vt_num = 4'd11;
    end else if (scancode == SC_F12) begin
      vt_num = 4'd12;
    end
  end

  always_comb begin
    map_ch = 7'h00;
    if (scancode < 8'(MapSize)) begin
      map_ch = shift_r ? SHIFT_MAP[scancode[5:0]] : PLAIN_MAP[scancode[5:0]];
    end
    is_letter = (map_ch >= 7'h61 && map_ch <= 7'h7A) ||
                (map_ch >= 7'h41 && map_ch <= 7'h5A);
    key_ch = (ctrl_r && is_letter) ? (map_ch & CTRL_MASK) : map_ch;
  end

  always_comb begin
    shift_nxt   = shift_r;
    alt_nxt     = alt_r;
    ctrl_nxt    = ctrl_r;
    pend_nxt    = 1'b0;
    burst.kind  = KIND_CHAR;
    burst.vt    = 4'd0;
    burst.cnt   = 3'd0;
    burst.chars = {CH_TILDE, nav_ch, CH_BRACKET, CH_ESC};
    if (pend_r) begin
      if (nav_hit) begin
        burst.cnt = nav_long ? 3'd4 : 3'd3;
      end
    end else if (scancode == SC_PREFIX) begin
      pend_nxt = 1'b1;
    end else if (scancode[7]) begin
      if (scancode[6:0] == SC_LSHIFT || scancode[6:0] == SC_RSHIFT) begin
        shift_nxt = 1'b0;
      end
      if (scancode[6:0] == SC_ALT) begin
        alt_nxt = 1'b0;
      end
      if (scancode[6:0] == SC_CTRL) begin
        ctrl_nxt = 1'b0;
      end
    end else if (scancode[6:0] == SC_LSHIFT || scancode[6:0] == SC_RSHIFT) begin
      shift_nxt = 1'b1;
    end else if (scancode[6:0] == SC_ALT) begin
      alt_nxt = 1'b1;
    end else if (scancode[6:0] == SC_CTRL) begin
      ctrl_nxt = 1'b1;
    end else if (alt_r && vt_num != 4'd0) begin
      burst.kind  = KIND_VT;
      burst.vt    = vt_num;
      burst.cnt   = 3'd1;
      burst.chars = '0;
    end else if (nav_hit) begin
      burst.cnt = nav_long ? 3'd4 : 3'd3;
    end else if (key_ch != 7'h00) begin
      burst.cnt   = 3'd1;
      burst.chars = {21'd0, key_ch};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      shift_r <= 1'b0;
      alt_r   <= 1'b0;
      ctrl_r  <= 1'b0;
      pend_r  <= 1'b0;
    end else if (advance) begin
      shift_r <= shift_nxt;
      alt_r   <= alt_nxt;
      ctrl_r  <= ctrl_nxt;
      pend_r  <= pend_nxt;
    end
  end

endmodule

### hw/rtl/sc1a_emit.sv
module sc1a_emit (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 load,
  input  sc1a_pkg::burst_t     burst,
  output sc1a_pkg::emit_stat_t stat,
  output logic                 out_tvalid,
  input  logic                 out_tready,
  output logic [15:0]          out_tdata,  // [6:0] char_code, [10:7] vt_number, zero above
  output logic                 out_tuser,  // kind
  output logic                 out_tlast
);
  import sc1a_pkg::*;

  burst_t burst_r;
  burst_t burst_nxt;
  logic   xfer;

  assign out_tvalid = burst_r.cnt != 3'd0;
  assign xfer       = out_tvalid && out_tready;
  assign out_tlast  = burst_r.cnt == 3'd1;
  assign out_tuser  = burst_r.kind;
  assign out_tdata  = {5'd0, burst_r.vt, burst_r.chars[0]};
  assign stat.free  = !out_tvalid || (out_tlast && out_tready);

  always_comb begin
    burst_nxt = burst_r;
    if (load) begin
      burst_nxt = burst;
    end else if (xfer) begin
      burst_nxt.cnt   = burst_r.cnt - 3'd1;
      burst_nxt.chars = {7'h00, burst_r.chars[MaxRes-1:1]};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      burst_r.cnt <= 3'd0;
    end else begin
      burst_r.cnt <= burst_nxt.cnt;
    end
    burst_r.kind  <= burst_nxt.kind;
    burst_r.vt    <= burst_nxt.vt;
    burst_r.chars <= burst_nxt.chars;
  end

endmodule

### hw/rtl/scancode_set1_to_ascii.sv
// Set-1 keyboard scancode decoder. Each transfer on the in_ side carries one raw scancode
// byte; the block tracks shift, alt, ctrl and a pending E0 prefix and answers with zero to
// four results: an ASCII or control character, a three- or four-character ANSI escape
// sequence for the navigation keys, or a terminal switch request (tuser high) for alt with
// a function key. The final result of each scancode carries tlast. An escape sequence holds
// the output register until its last character is taken, one character per transfer, and
// this output register sets the sustained rate, as a buffered scancode is decoded only once
// the last result of the one before it is taken. The input register takes a new byte while
// the previous results are still being delivered.
module scancode_set1_to_ascii (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,   // [7:0] scancode
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [15:0] out_tdata,  // [6:0] char_code, [10:7] vt_number, zero above
  output logic        out_tuser,  // kind
  output logic        out_tlast
);
  import sc1a_pkg::*;

  logic       in_valid_r;
  logic [7:0] sc_r;
  logic       advance;
  burst_t     dec_burst;
  emit_stat_t emit_stat;

  assign advance   = in_valid_r && emit_stat.free;
  assign in_tready = !in_valid_r || advance;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r <= 1'b0;
    end else if (in_tready) begin
      in_valid_r <= in_tvalid;
    end
    if (in_tready && in_tvalid) begin
      sc_r <= in_tdata;
    end
  end

  sc1a_decode u_decode (
    .clk      (clk),
    .rst_n    (rst_n),
    .scancode (sc_r),
    .advance  (advance),
    .burst    (dec_burst)
  );

  sc1a_emit u_emit (
    .clk        (clk),
    .rst_n      (rst_n),
    .load       (advance),
    .burst      (dec_burst),
    .stat       (emit_stat),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast)
  );

  a_burst_len: assert property (@(posedge clk) disable iff (!rst_n)
    advance |-> dec_burst.cnt <= 3'(MaxRes))
    else $error("Decoded burst is longer than four results.");

  a_vt_single: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser == KIND_VT |-> out_tlast && out_tdata[6:0] == 7'h00)
    else $error("Terminal switch result is not a single clean transfer.");

  a_char_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser == KIND_CHAR |-> out_tdata[6:0] != 7'h00
                                          && out_tdata[10:7] == 4'd0)
    else $error("Character result carries a zero code or a terminal number.");

  a_hold_input: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid_r && !advance |=> in_valid_r && $stable(sc_r))
    else $error("Buffered scancode lost before it was decoded.");

endmodule

### bench/scancode_decode_checker.sv
module scancode_decode_checker (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  input  logic        in_tready,
  input  logic [7:0]  in_tdata,
  input  logic        out_tvalid,
  input  logic        out_tready,
  input  logic [15:0] out_tdata,
  input  logic        out_tuser,
  input  logic        out_tlast,
  output int          mismatches,
  output int          results_left
);
  import sc1a_pkg::*;

  typedef struct packed {
    logic       kind;
    logic [6:0] char_code;
    logic [3:0] vt_number;
    logic       last;
  } key_result_t;

  localparam logic [6:0] KEYS_PLAIN [0:57] = '{
    7'h00, 7'h1B, 7'h31, 7'h32, 7'h33, 7'h34, 7'h35, 7'h36,
    7'h37, 7'h38, 7'h39, 7'h30, 7'h2D, 7'h3D, 7'h08, 7'h09,
    7'h71, 7'h77, 7'h65, 7'h72, 7'h74, 7'h79, 7'h75, 7'h69,
    7'h6F, 7'h70, 7'h5B, 7'h5D, 7'h0A, 7'h00, 7'h61, 7'h73,
    7'h64, 7'h66, 7'h67, 7'h68, 7'h6A, 7'h6B, 7'h6C, 7'h3B,
    7'h27, 7'h60, 7'h00, 7'h5C, 7'h7A, 7'h78, 7'h63, 7'h76,
    7'h62, 7'h6E, 7'h6D, 7'h2C, 7'h2E, 7'h2F, 7'h00, 7'h2A,
    7'h00, 7'h20
  };

  localparam logic [6:0] KEYS_SHIFTED [0:57] = '{
    7'h00, 7'h1B, 7'h21, 7'h40, 7'h23, 7'h24, 7'h25, 7'h5E,
    7'h26, 7'h2A, 7'h28, 7'h29, 7'h5F, 7'h2B, 7'h08, 7'h09,
    7'h51, 7'h57, 7'h45, 7'h52, 7'h54, 7'h59, 7'h55, 7'h49,
    7'h4F, 7'h50, 7'h7B, 7'h7D, 7'h0A, 7'h00, 7'h41, 7'h53,
    7'h44, 7'h46, 7'h47, 7'h48, 7'h4A, 7'h4B, 7'h4C, 7'h3A,
    7'h22, 7'h7E, 7'h00, 7'h7C, 7'h5A, 7'h58, 7'h43, 7'h56,
    7'h42, 7'h4E, 7'h4D, 7'h3C, 7'h3E, 7'h3F, 7'h00, 7'h2A,
    7'h00, 7'h20
  };

  key_result_t chars_due[$];
  logic        shift_on;
  logic        alt_on;
  logic        ctrl_on;
  logic        e0_seen;

  function automatic void queue_result(logic kind, logic [6:0] ch, logic [3:0] vt,
                                       logic last);
    key_result_t r;
    r.kind      = kind;
    r.char_code = ch;
    r.vt_number = vt;
    r.last      = last;
    chars_due.push_back(r);
  endfunction

  function automatic int queue_escape(logic [7:0] code);
    logic [6:0] final_char;
    int         n;
    n = 3;
    case (code)
      SC_UP:    final_char = 7'h41;
      SC_DOWN:  final_char = 7'h42;
      SC_RIGHT: final_char = 7'h43;
      SC_LEFT:  final_char = 7'h44;
      SC_HOME:  final_char = 7'h48;
      SC_END:   final_char = 7'h46;
      SC_INS: begin
        final_char = 7'h32;
        n = 4;
      end
      SC_DEL: begin
        final_char = 7'h33;
        n = 4;
      end
      default: return 0;
    endcase
    queue_result(KIND_CHAR, CH_ESC, 4'd0, 1'b0);
    queue_result(KIND_CHAR, CH_BRACKET, 4'd0, 1'b0);
    queue_result(KIND_CHAR, final_char, 4'd0, n == 3);
    if (n == 4) queue_result(KIND_CHAR, CH_TILDE, 4'd0, 1'b1);
    return n;
  endfunction

  function automatic void decode_scancode(logic [7:0] sc);
    logic [3:0] vt;
    logic [6:0] ch;
    vt = 4'd0;
    if (e0_seen) begin
      e0_seen = 1'b0;
      void'(queue_escape(sc));
    end else if (sc == SC_PREFIX) begin
      e0_seen = 1'b1;
    end else if (sc[7]) begin
      if (sc[6:0] == SC_LSHIFT || sc[6:0] == SC_RSHIFT) shift_on = 1'b0;
      if (sc[6:0] == SC_ALT) alt_on = 1'b0;
      if (sc[6:0] == SC_CTRL) ctrl_on = 1'b0;
    end else if (sc[6:0] == SC_LSHIFT || sc[6:0] == SC_RSHIFT) begin
      shift_on = 1'b1;
    end else if (sc[6:0] == SC_ALT) begin
      alt_on = 1'b1;
    end else if (sc[6:0] == SC_CTRL) begin
      ctrl_on = 1'b1;
    end else begin
      if (alt_on) begin
        if (sc >= SC_F1 && sc <= SC_F10) vt = 4'(sc - SC_F1 + 8'd1);
        else if (sc == SC_F11) vt = 4'd11;
        else if (sc == SC_F12) vt = 4'd12;
      end
      if (vt != 4'd0) begin
        queue_result(KIND_VT, 7'd0, vt, 1'b1);
      end else if (queue_escape(sc) == 0 && int'(sc) < MapSize) begin
        ch = shift_on ? KEYS_SHIFTED[sc] : KEYS_PLAIN[sc];
        if (ctrl_on && ((ch >= 7'h61 && ch <= 7'h7A) || (ch >= 7'h41 && ch <= 7'h5A)))
          ch = ch & CTRL_MASK;
        if (ch != 7'd0) queue_result(KIND_CHAR, ch, 4'd0, 1'b1);
      end
    end
  endfunction

  initial begin
    mismatches   = 0;
    results_left = 0;
  end

  always @(posedge clk) begin
    key_result_t want;
    if (!rst_n) begin
      shift_on = 1'b0;
      alt_on   = 1'b0;
      ctrl_on  = 1'b0;
      e0_seen  = 1'b0;
      chars_due.delete();
    end else begin
      if (in_tvalid && in_tready) decode_scancode(in_tdata);
      if (out_tvalid && out_tready) begin
        if (chars_due.size() == 0) begin
          mismatches++;
          $display("%0t: unexpected result: kind %0d data %h last %0d", $time,
                   out_tuser, out_tdata, out_tlast);
        end else begin
          want = chars_due.pop_front();
          if (out_tuser !== want.kind || out_tdata !== {5'd0, want.vt_number, want.char_code}
              || out_tlast !== want.last) begin
            mismatches++;
            $display("%0t: expected kind %0d char %h vt %0d last %0d,",
                     $time, want.kind, want.char_code, want.vt_number, want.last,
                     " got kind %0d char %h vt %0d last %0d (data %h)",
                     out_tuser, out_tdata[6:0], out_tdata[10:7], out_tlast, out_tdata);
          end
        end
      end
    end
    results_left = chars_due.size();
  end

endmodule

### bench/scancode_set1_to_ascii_tb.sv
module scancode_set1_to_ascii_tb;
  import sc1a_pkg::*;

  localparam int CycleLimit = 200000;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [7:0]  in_tdata = 8'd0;
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [15:0] out_tdata;
  logic        out_tuser;
  logic        out_tlast;
  int          mismatches;
  int          results_left;
  int          cycles = 0;
  int          tx_idle_pct = 36;
  int          rx_idle_pct = 50;

  localparam logic [7:0] NAV_KEYS [0:7] = '{
    SC_UP, SC_DOWN, SC_LEFT, SC_RIGHT, SC_HOME, SC_END, SC_INS, SC_DEL
  };
  localparam logic [6:0] MODIFIERS [0:3] = '{SC_LSHIFT, SC_RSHIFT, SC_ALT, SC_CTRL};

  localparam logic [7:0] OPENING_KEYS [0:26] = '{
    8'h00, 8'hFF, 8'h7F, 8'h3A, 8'h1E,
    {1'b0, SC_LSHIFT}, 8'h10, {1'b1, SC_LSHIFT},
    {1'b0, SC_RSHIFT}, 8'h02, {1'b1, SC_RSHIFT},
    {1'b0, SC_CTRL}, 8'h1E, {1'b1, SC_CTRL},
    {1'b0, SC_ALT}, SC_F1, SC_F10, SC_F12, SC_UP, {1'b1, SC_ALT},
    SC_DEL, SC_PREFIX, SC_LEFT, SC_PREFIX, SC_PREFIX, 8'h39, 8'h39
  };

  scancode_set1_to_ascii i_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast)
  );

  scancode_decode_checker i_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_tvalid    (in_tvalid),
    .in_tready    (in_tready),
    .in_tdata     (in_tdata),
    .out_tvalid   (out_tvalid),
    .out_tready   (out_tready),
    .out_tdata    (out_tdata),
    .out_tuser    (out_tuser),
    .out_tlast    (out_tlast),
    .mismatches   (mismatches),
    .results_left (results_left)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == CycleLimit) begin
      $display("DONE: errors detected");
      $finish;
    end
  end

  always @(negedge clk) begin
    out_tready <= ($urandom_range(99) >= rx_idle_pct);
  end

  task automatic send_scancode(input logic [7:0] sc);
    while ($urandom_range(99) < tx_idle_pct) begin
      in_tvalid <= 1'b0;
      @(negedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= sc;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic await_drain();
    in_tvalid <= 1'b0;
    @(negedge clk);
    while (results_left != 0) @(negedge clk);
    repeat (8) @(negedge clk);
  endtask

  task automatic send_random_action(output bit is_key);
    int          pick;
    logic [7:0]  fkey;
    pick   = $urandom_range(99);
    is_key = 1'b1;
    if (pick < 40) begin
      send_scancode(8'($urandom_range(MapSize)));
    end else if (pick < 55) begin
      if ($urandom_range(1) == 1) send_scancode(SC_PREFIX);
      send_scancode(NAV_KEYS[$urandom_range(7)]);
    end else if (pick < 65) begin
      case ($urandom_range(2))
        0:       fkey = 8'($urandom_range(SC_F1, SC_F10));
        1:       fkey = SC_F11;
        default: fkey = SC_F12;
      endcase
      send_scancode({1'b0, SC_ALT});
      send_scancode(fkey);
      if ($urandom_range(1) == 1) send_scancode({1'b1, SC_ALT});
    end else if (pick < 80) begin
      is_key = 1'b0;
      send_scancode({1'($urandom_range(1)), MODIFIERS[$urandom_range(3)]});
    end else if (pick < 88) begin
      send_scancode(SC_PREFIX);
      send_scancode(8'($urandom_range(255)));
    end else begin
      is_key = 1'b0;
      send_scancode(8'($urandom_range(255)));
    end
  endtask

  task automatic run_phase(input int tx_pct, input int rx_pct, input int keys_wanted);
    int keys_done;
    bit is_key;
    keys_done   = 0;
    tx_idle_pct = tx_pct;
    rx_idle_pct = rx_pct;
    while (keys_done < keys_wanted) begin
      send_random_action(is_key);
      if (is_key) keys_done++;
      if (keys_done == keys_wanted / 2 && is_key) await_drain();
    end
    await_drain();
  endtask

  initial begin
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);
    foreach (OPENING_KEYS[i]) send_scancode(OPENING_KEYS[i]);
    await_drain();
    run_phase(36, 50, 42);
    run_phase(50, 36, 42);
    run_phase(0, 0, 42);
    if (mismatches == 0 && results_left == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
